### rtl/articulation_point_finder_defines.svh
// Assertion macros for the articulation point finder checker.
// No dependencies; included by files that carry assertions.
`ifndef ARTICULATION_POINT_FINDER_DEFINES_SVH
`define ARTICULATION_POINT_FINDER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define APF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("apf check failed");

// Next-cycle implication.
`define APF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("apf check failed");

`endif

### rtl/apf_pkg.sv
// Shared types and constants of the articulation point finder.
// No dependencies.
package apf_pkg;
	localparam int VW = 7;
	localparam int TW = 7;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ROOT, ST_EDGE_RD, ST_EDGE_CHK, ST_BACK, ST_POP, ST_POP_WAIT, ST_OUT
	} state_t;

	typedef struct packed {
		logic [VW-1:0] cut_vertex;
		logic          none_found;
		logic          edges_dropped;
		logic          last_result;
	} res_t;
endpackage

### rtl/apf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module apf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

### rtl/apf_core.sv
// Edge loader, depth-first cut-vertex search and result scan.
// Depends on apf_pkg and apf_ram (edge store, discovery times, frame stack).
module apf_core
	import apf_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [VW-1:0] first_vertex,
	input  logic [VW-1:0] second_vertex,
	input  logic          last_edge,
	input  logic [VW-1:0] vcount,
	output logic          busy,
	output logic          res_valid,
	output res_t          res
);
	localparam int VIW = $clog2(MAX_VERTICES + 1);
	localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int FW = 2 * VW + CW + 2 * TW;

	state_t state_q, state_d;
	logic [VW-1:0] n;
	logic [CW-1:0] edge_total_q, cursor_q;
	logic drop_q;
	logic [VW:0] i_q;
	logic [VW-1:0] u_q, par_q, root_q, pend_v_q;
	logic [TW-1:0] low_q, disc_q, time_q;
	logic [VIW-1:0] depth_q;
	logic [1:0] rc_q;
	logic [MAX_VERTICES:0] visited_q, cut_q;
	logic pend_q, res_valid_q;
	res_t res_q;

	logic accept, a_ok, b_ok, load;
	logic e_we, d_we, s_we;
	logic [EIW-1:0] e_raddr;
	logic [2*VW-1:0] e_rdata;
	logic [VW-1:0] ea, eb, w;
	logic w_ok, w_new;
	logic [VW-1:0] d_waddr_v;
	logic [TW-1:0] d_wdata, d_rdata, time_inc;
	logic [VIW-1:0] s_addr;
	logic [FW-1:0] s_wdata, s_rdata;
	logic [VW-1:0] p_v, p_par;
	logic [CW-1:0] p_cur;
	logic [TW-1:0] p_low, p_disc;
	logic in_range, is_cut;

	assign n = (32'(vcount) > MAX_VERTICES) ? VW'(MAX_VERTICES) : vcount;
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign a_ok = (first_vertex != '0) && (first_vertex <= n);
	assign b_ok = (second_vertex != '0) && (second_vertex <= n);
	assign load = accept && a_ok && b_ok && (first_vertex != second_vertex)
		&& (edge_total_q != CW'(MAX_EDGES));
	assign time_inc = time_q + TW'(1);

	assign ea = e_rdata[2*VW-1:VW];
	assign eb = e_rdata[VW-1:0];
	assign w = (ea == u_q) ? eb : ((eb == u_q) ? ea : '0);
	assign w_ok = ((ea == u_q) || (eb == u_q)) && (w != '0) && (w <= n) && (w != par_q);
	assign w_new = !visited_q[VIW'(w)];
	assign {p_v, p_par, p_cur, p_low, p_disc} = s_rdata;
	assign in_range = (i_q <= {1'b0, n});
	assign is_cut = cut_q[VIW'(i_q)];

	// Memory port control.
	assign e_we = load;
	assign e_raddr = EIW'(cursor_q);
	assign d_we = ((state_q == ST_ROOT) && in_range && !visited_q[VIW'(i_q)])
		|| ((state_q == ST_EDGE_CHK) && w_ok && w_new);
	assign d_waddr_v = (state_q == ST_ROOT) ? i_q[VW-1:0] : w;
	assign d_wdata = time_inc;
	assign s_we = (state_q == ST_EDGE_CHK) && w_ok && w_new;
	assign s_addr = (state_q == ST_POP) ? (depth_q - VIW'(2)) : (depth_q - VIW'(1));
	assign s_wdata = {u_q, par_q, cursor_q, low_q, disc_q};

	apf_ram #(.WIDTH(2 * VW), .DEPTH(MAX_EDGES), .AW(EIW)) u_edge_ram (
		.clk(clk), .we(e_we), .waddr(EIW'(edge_total_q)),
		.wdata({first_vertex, second_vertex}), .raddr(e_raddr), .rdata(e_rdata)
	);

	apf_ram #(.WIDTH(TW), .DEPTH(MAX_VERTICES + 1), .AW(VIW)) u_disc_ram (
		.clk(clk), .we(d_we), .waddr(VIW'(d_waddr_v)), .wdata(d_wdata),
		.raddr(VIW'(w)), .rdata(d_rdata)
	);

	apf_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES + 1), .AW(VIW)) u_stack_ram (
		.clk(clk), .we(s_we), .waddr(s_addr), .wdata(s_wdata),
		.raddr(s_addr), .rdata(s_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && last_edge) state_d = ST_ROOT;
			ST_ROOT: begin
				if (!in_range) state_d = ST_OUT;
				else if (!visited_q[VIW'(i_q)]) state_d = ST_EDGE_RD;
			end
			ST_EDGE_RD: state_d = (cursor_q < edge_total_q) ? ST_EDGE_CHK : ST_POP;
			ST_EDGE_CHK: begin
				if (w_ok && !w_new) state_d = ST_BACK;
				else state_d = ST_EDGE_RD;
			end
			ST_BACK: state_d = ST_EDGE_RD;
			ST_POP: state_d = (depth_q > VIW'(1)) ? ST_POP_WAIT : ST_ROOT;
			ST_POP_WAIT: state_d = ST_EDGE_RD;
			ST_OUT: if (!in_range) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			edge_total_q <= '0;
			drop_q <= 1'b0;
			res_valid_q <= 1'b0;
			pend_q <= 1'b0;
			visited_q <= '0;
			cut_q <= '0;
			time_q <= '0;
			depth_q <= '0;
			rc_q <= '0;
			i_q <= '0;
		end else begin
			state_q <= state_d;
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (load) edge_total_q <= edge_total_q + CW'(1);
						else if (!a_ok || !b_ok || (first_vertex != second_vertex))
							drop_q <= 1'b1;
						if (last_edge) begin
							visited_q <= '0;
							cut_q <= '0;
							time_q <= '0;
							i_q <= (VW + 1)'(1);
						end
					end
				end
				ST_ROOT: begin
					if (!in_range) begin
						i_q <= (VW + 1)'(1);
						pend_q <= 1'b0;
					end else if (visited_q[VIW'(i_q)]) begin
						i_q <= i_q + (VW + 1)'(1);
					end else begin
						visited_q[VIW'(i_q)] <= 1'b1;
						time_q <= time_inc;
						root_q <= i_q[VW-1:0];
						rc_q <= '0;
						u_q <= i_q[VW-1:0];
						par_q <= '0;
						cursor_q <= '0;
						low_q <= time_inc;
						disc_q <= time_inc;
						depth_q <= VIW'(1);
					end
				end
				ST_EDGE_RD: begin
					if (cursor_q < edge_total_q) cursor_q <= cursor_q + CW'(1);
				end
				ST_EDGE_CHK: begin
					if (w_ok && w_new) begin
						if ((u_q == root_q) && (rc_q != 2'd2)) rc_q <= rc_q + 2'd1;
						visited_q[VIW'(w)] <= 1'b1;
						time_q <= time_inc;
						u_q <= w;
						par_q <= u_q;
						cursor_q <= '0;
						low_q <= time_inc;
						disc_q <= time_inc;
						depth_q <= depth_q + VIW'(1);
					end
				end
				ST_BACK: begin
					if (d_rdata < low_q) low_q <= d_rdata;
				end
				ST_POP: begin
					if (depth_q > VIW'(1)) begin
						depth_q <= depth_q - VIW'(1);
					end else begin
						depth_q <= '0;
						if (rc_q == 2'd2) cut_q[VIW'(root_q)] <= 1'b1;
						i_q <= i_q + (VW + 1)'(1);
					end
				end
				ST_POP_WAIT: begin
					// The child's values are still in the frame registers here.
					u_q <= p_v;
					par_q <= p_par;
					cursor_q <= p_cur;
					disc_q <= p_disc;
					low_q <= (low_q < p_low) ? low_q : p_low;
					if ((p_v != root_q) && (low_q >= p_disc)) cut_q[VIW'(p_v)] <= 1'b1;
				end
				ST_OUT: begin
					// One cut vertex is held back so the final word can carry the last mark.
					if (in_range) begin
						if (is_cut) begin
							if (pend_q) begin
								res_valid_q <= 1'b1;
								res_q <= '{pend_v_q, 1'b0, drop_q, 1'b0};
							end
							pend_q <= 1'b1;
							pend_v_q <= i_q[VW-1:0];
						end
						i_q <= i_q + (VW + 1)'(1);
					end else begin
						res_valid_q <= 1'b1;
						if (pend_q) res_q <= '{pend_v_q, 1'b0, drop_q, 1'b1};
						else res_q <= '{VW'(0), 1'b1, drop_q, 1'b1};
						pend_q <= 1'b0;
						edge_total_q <= '0;
						drop_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;
endmodule

### rtl/articulation_point_finder.sv
// Top level of the articulation point finder: configuration port and search core.
// Depends on apf_pkg and apf_core.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------------
//  edge in   | start & !busy         | first_vertex, second_vertex, last_edge
//  result    | result_strobe         | cut_vertex, none_found, edges_dropped, last_result
//  config    | psel&penable&pwrite   | pwdata -> vertex_count (any address)
//
// Edge words are taken back to back while busy is low. After the last edge, busy stays
// high while every frame steps its cursor over all E stored edges (a read, then a
// check); back edges add an update step, and pops a pop step plus a wait step when a
// parent frame resumes. The scan then visits the V cut marks, one per cycle; each word
// shows in the cycle after the next cut mark is found, and the final word as busy falls.
// Reset clears control state and sets vertex_count to 64; there is no clearing pass.
// The receiver cannot stall; each result word is shown for one cycle.
module articulation_point_finder
	import apf_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [VW-1:0] first_vertex,
	input  logic [VW-1:0] second_vertex,
	input  logic          last_edge,
	output logic          result_strobe,
	output logic [VW-1:0] cut_vertex,
	output logic          none_found,
	output logic          edges_dropped,
	output logic          last_result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	logic [VW-1:0] vertex_count_q;
	res_t res;

	// Only one register, so every address maps to it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VW'(64);
		end else if (psel && penable && pwrite) begin
			vertex_count_q <= pwdata[VW-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {25'd0, vertex_count_q} : {25'd0, vertex_count_q};

	apf_core #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .first_vertex(first_vertex),
		.second_vertex(second_vertex), .last_edge(last_edge), .vcount(vertex_count_q),
		.busy(busy), .res_valid(result_strobe), .res(res)
	);

	assign cut_vertex = res.cut_vertex;
	assign none_found = res.none_found;
	assign edges_dropped = res.edges_dropped;
	assign last_result = res.last_result;
endmodule

### rtl/apf_checker.sv
// Port-level checks of the articulation point finder, bound to the top level.
// Depends on articulation_point_finder_defines.svh.
`include "articulation_point_finder_defines.svh"
module apf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       busy,
	input logic       result_strobe,
	input logic [6:0] cut_vertex,
	input logic       none_found,
	input logic       last_result
);
	`APF_ASSERT_NOW(none_is_single, result_strobe && none_found, last_result && (cut_vertex == 7'd0))
	`APF_ASSERT_NOW(cut_nonzero, result_strobe && !none_found, cut_vertex != 7'd0)
	`APF_ASSERT_NOW(more_while_busy, result_strobe && !last_result, busy)
	`APF_ASSERT_NEXT(quiet_after_last, result_strobe && last_result, !result_strobe)
endmodule

bind articulation_point_finder apf_checker u_apf_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .result_strobe(result_strobe),
	.cut_vertex(cut_vertex), .none_found(none_found), .last_result(last_result)
);
